// File: rtl/iorb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iorb_pkg
// Shared types and constants for the in-order release buffer: sequence width,
// parameter defaults, mode and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iorb_pkg;

	localparam int SEQ_BITS         = 16;
	localparam int WINDOW_DEF       = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam logic MODE_RECORD  = 1'b0;
	localparam logic MODE_ABANDON = 1'b1;

	localparam logic STATUS_RELEASE = 1'b0;
	localparam logic STATUS_REJECT  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN_RD,
		ST_DRAIN_EX
	} state_t;

	typedef struct packed {
		logic cap;
		logic reject;
		logic store;
		logic head;
		logic step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic dist_zero;
		logic in_window;
		logic hit;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/iorb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iorb_ctrl
// Controller: accepts a request, classifies it against the expected number
// and sequences the retire and drain walk through the window.
// ----------------------------------------------------------------------------
module iorb_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  iorb_pkg::sts_t   sts,
	output iorb_pkg::cmd_t   cmd
);
	import iorb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.cap = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.dist_zero) begin
					cmd.head = 1'b1;
					state_d  = ST_DRAIN_RD;
				end else if (sts.in_window) begin
					cmd.store = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.reject = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN_EX;
			end
			ST_DRAIN_EX: begin
				if (sts.hit) begin
					cmd.step = 1'b1;
					state_d  = ST_DRAIN_RD;
				end else begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/iorb_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iorb_dpath
// Datapath: request capture, expected number and its window index, pending
// slot flags and storage, one-deep hold of the next released record so the
// final result can be marked, and the result register.
// ----------------------------------------------------------------------------
module iorb_dpath #(
	parameter int WINDOW       = iorb_pkg::WINDOW_DEF,
	parameter int PAYLOAD_BITS = iorb_pkg::PAYLOAD_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  iorb_pkg::cmd_t                  cmd,
	output iorb_pkg::sts_t                  sts,
	input  wire                             mode,
	input  wire [iorb_pkg::SEQ_BITS-1:0]    seq_num,
	input  wire [PAYLOAD_BITS-1:0]          payload,
	output logic                            valid,
	output logic                            status,
	output logic [PAYLOAD_BITS-1:0]         out_payload,
	output logic [iorb_pkg::SEQ_BITS-1:0]   out_seq,
	output logic                            last
);
	import iorb_pkg::*;

	localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W    = IDX_W + 2;
	localparam int SEQ_SPAN = 2 ** SEQ_BITS;
	localparam int WRAP_ADJ = (WINDOW - (SEQ_SPAN % WINDOW)) % WINDOW;
	localparam logic [SUM_W-1:0] W1_S  = SUM_W'(WINDOW);
	localparam logic [SUM_W-1:0] W2_S  = SUM_W'(2 * WINDOW);
	localparam logic [SUM_W-1:0] ADJ_S = SUM_W'(WRAP_ADJ);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	// captured request
	logic                    mode_q;
	logic [SEQ_BITS-1:0]     seq_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// retire position
	logic [SEQ_BITS-1:0]     exp_q;
	logic [IDX_W-1:0]        idx_q;

	// pending slots
	logic [WINDOW-1:0]       slot_vld_q;
	logic                    mem_aband [WINDOW];
	logic [PAYLOAD_BITS-1:0] mem_pay [WINDOW];
	logic                    rd_aband_q;
	logic [PAYLOAD_BITS-1:0] rd_pay_q;

	// held record awaiting its last flag
	logic                    pend_q;
	logic [PAYLOAD_BITS-1:0] pend_pay_q;
	logic [SEQ_BITS-1:0]     pend_seq_q;

	// result register
	logic                    res_vld_q;
	logic                    res_status_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic [SEQ_BITS-1:0]     res_seq_q;
	logic                    res_last_q;

	logic [SEQ_BITS-1:0]     delta;
	logic                    wrap;
	logic [SUM_W-1:0]        slot_sum;
	logic [SUM_W-1:0]        slot_red;
	logic [IDX_W-1:0]        slot;
	logic [IDX_W-1:0]        idx_next;
	logic                    advance;
	logic                    take_rec;
	logic                    emit_pend;

	// slot of the captured number, seq mod window, from the expected index
	always_comb begin
		delta    = seq_q - exp_q;
		wrap     = (seq_q < exp_q);
		slot_sum = SUM_W'(idx_q) + SUM_W'(delta[IDX_W-1:0]) + (wrap ? ADJ_S : '0);
		if (slot_sum >= W2_S) begin
			slot_red = slot_sum - W2_S;
		end else if (slot_sum >= W1_S) begin
			slot_red = slot_sum - W1_S;
		end else begin
			slot_red = slot_sum;
		end
		slot = slot_red[IDX_W-1:0];
	end

	always_comb begin
		if (exp_q == '1 || idx_q == IDX_LAST) begin
			idx_next = '0;
		end else begin
			idx_next = idx_q + IDX_W'(1);
		end
	end

	assign advance   = cmd.head || cmd.step;
	assign take_rec  = (cmd.head && mode_q == MODE_RECORD) || (cmd.step && !rd_aband_q);
	assign emit_pend = pend_q && ((cmd.step && !rd_aband_q) || cmd.flush);

	assign sts.dist_zero = (delta == '0);
	assign sts.in_window = (delta < SEQ_BITS'(WINDOW));
	assign sts.hit       = slot_vld_q[idx_q];

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			seq_q  <= seq_num;
			pay_q  <= payload;
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem_aband[slot] <= mode_q;
			mem_pay[slot]   <= (mode_q == MODE_ABANDON) ? '0 : pay_q;
		end
		rd_aband_q <= mem_aband[idx_q];
		rd_pay_q   <= mem_pay[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q      <= '0;
			idx_q      <= '0;
			slot_vld_q <= '0;
			pend_q     <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= cmd.reject || emit_pend;
			if (cmd.store) begin
				slot_vld_q[slot] <= 1'b1;
			end
			if (advance) begin
				slot_vld_q[idx_q] <= 1'b0;
				exp_q             <= exp_q + SEQ_BITS'(1);
				idx_q             <= idx_next;
			end
			if (cmd.head) begin
				pend_q <= (mode_q == MODE_RECORD);
			end else if (cmd.step && !rd_aband_q) begin
				pend_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_rec) begin
			pend_pay_q <= cmd.head ? pay_q : rd_pay_q;
			pend_seq_q <= exp_q;
		end
		if (cmd.reject) begin
			res_status_q <= STATUS_REJECT;
			res_pay_q    <= '0;
			res_seq_q    <= seq_q;
			res_last_q   <= 1'b1;
		end else if (emit_pend) begin
			res_status_q <= STATUS_RELEASE;
			res_pay_q    <= pend_pay_q;
			res_seq_q    <= pend_seq_q;
			res_last_q   <= cmd.flush;
		end
	end

	assign valid       = res_vld_q;
	assign status      = res_status_q;
	assign out_payload = res_pay_q;
	assign out_seq     = res_seq_q;
	assign last        = res_last_q;

`ifndef SYNTHESIS
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == STATUS_REJECT) |-> (last && out_payload == '0))
		else $error("reject result malformed");

	a_store_sets_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> slot_vld_q[$past(slot)])
		else $error("stored slot not marked pending");

	a_advance_expected: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (exp_q == $past(exp_q) + SEQ_BITS'(1)))
		else $error("expected number did not advance");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && pend_q) |=> (valid && last && status == STATUS_RELEASE))
		else $error("held record not released as last");

	a_no_drop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !rd_aband_q && pend_q) |=> (valid && !last))
		else $error("held record lost during drain");
`endif

endmodule
`default_nettype wire

// File: rtl/in_order_release_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// in_order_release_buffer
// Releases tagged completions strictly in sequence order through a window of
// pending slots; out-of-window completions are rejected with a status result.
// ----------------------------------------------------------------------------
// A store or reject holds busy through the evaluate state after the accepting
//   edge; a reject result shows in the cycle after that. A request at the
//   expected number also holds busy for a read and an examine state per slot
//   walked, the drained ones and the empty one (registered slot read).
// Results are strobed by valid for one cycle each; the receiver cannot stall.
// Reset clears the expected number, all pending flags and the controller.
module in_order_release_buffer #(
	parameter int WINDOW       = iorb_pkg::WINDOW_DEF,
	parameter int PAYLOAD_BITS = iorb_pkg::PAYLOAD_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             mode,
	input  wire [iorb_pkg::SEQ_BITS-1:0]    seq_num,
	input  wire [PAYLOAD_BITS-1:0]          payload,
	output logic                            valid,
	output logic                            status,
	output logic [PAYLOAD_BITS-1:0]         out_payload,
	output logic [iorb_pkg::SEQ_BITS-1:0]   out_seq,
	output logic                            last
);
	import iorb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	iorb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	iorb_dpath #(
		.WINDOW       (WINDOW),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.seq_num     (seq_num),
		.payload     (payload),
		.valid       (valid),
		.status      (status),
		.out_payload (out_payload),
		.out_seq     (out_seq),
		.last        (last)
	);

endmodule
`default_nettype wire

// File: test/tb_in_order_release_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_in_order_release_buffer
// Drives completions into the in-order release buffer and checks every
// released record and every rejection. A directed table comes first: records
// and abandonments at the head, stores at the window edge, overwrites,
// rejections of retired and far-ahead numbers, and a full 16-entry drain.
// A random phase follows, with mostly in-window traffic so the window fills
// and drains deeply. A behavioral copy of the release logic predicts each result
// the table does not give; all are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_in_order_release_buffer;
	import iorb_pkg::*;

	localparam int WIN         = WINDOW_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 450;

	typedef struct packed {
		logic                status;
		logic [31:0]         payload;
		logic [SEQ_BITS-1:0] seq;
		logic                last;
	} release_t;

	typedef struct {
		logic                m;
		logic [SEQ_BITS-1:0] s;
		logic [31:0]         p;
		bit                  typed;
		bit                  has_res;
		release_t            res;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                mode;
	logic [SEQ_BITS-1:0] seq_num;
	logic [31:0]         payload;
	logic                valid;
	logic                status;
	logic [31:0]         out_payload;
	logic [SEQ_BITS-1:0] out_seq;
	logic                last;

	in_order_release_buffer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.seq_num    (seq_num),
		.payload    (payload),
		.valid      (valid),
		.status     (status),
		.out_payload(out_payload),
		.out_seq    (out_seq),
		.last       (last)
	);

	// predicted buffer state
	logic [SEQ_BITS-1:0] next_seq;
	logic                pend_valid   [WIN];
	logic                pend_abandon [WIN];
	logic [31:0]         pend_payload [WIN];

	release_t  step_q[$];
	release_t  release_q[$];
	stim_row_t dir_rows[$];
	int        idle_pct;
	int        fail_cnt;
	int        cycle_cnt;
	release_t  got;
	release_t  want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic release_t mk_res(logic st, logic [31:0] p, logic [SEQ_BITS-1:0] s);
		release_t r;
		r.status  = st;
		r.payload = p;
		r.seq     = s;
		r.last    = 1'b1;
		return r;
	endfunction

	function automatic void add_row(logic m, logic [SEQ_BITS-1:0] s, logic [31:0] p,
			bit typed, bit has_res, release_t res);
		stim_row_t row;
		row.m       = m;
		row.s       = s;
		row.p       = p;
		row.typed   = typed;
		row.has_res = has_res;
		row.res     = res;
		dir_rows    = {dir_rows, row};
	endfunction

	// computes the results of one request and advances the predicted state
	task automatic predict_release(input logic m, input logic [SEQ_BITS-1:0] s,
			input logic [31:0] p);
		logic [SEQ_BITS-1:0] ahead;
		release_t            r;
		int                  idx;
		ahead = s - next_seq;
		step_q.delete();
		if (ahead == 0) begin
			pend_valid[s % WIN] = 1'b0;
			if (m == MODE_RECORD) begin
				r = mk_res(STATUS_RELEASE, p, s);
				step_q = {step_q, r};
			end
			next_seq = next_seq + 1'b1;
			idx = next_seq % WIN;
			while (pend_valid[idx]) begin
				pend_valid[idx] = 1'b0;
				if (!pend_abandon[idx]) begin
					r = mk_res(STATUS_RELEASE, pend_payload[idx], next_seq);
					step_q = {step_q, r};
				end
				next_seq = next_seq + 1'b1;
				idx = next_seq % WIN;
			end
		end else if (ahead < WIN) begin
			idx = s % WIN;
			pend_valid[idx]   = 1'b1;
			pend_abandon[idx] = (m == MODE_ABANDON);
			pend_payload[idx] = (m == MODE_ABANDON) ? 32'd0 : p;
		end else begin
			r = mk_res(STATUS_REJECT, 32'd0, s);
			step_q = {step_q, r};
		end
		foreach (step_q[i])
			step_q[i].last = (i == step_q.size() - 1);
	endtask

	// called at a falling edge, returns at a falling edge after the request is taken
	task automatic send_request(input logic m, input logic [SEQ_BITS-1:0] s,
			input logic [31:0] p, input bit typed, input bit has_res, input release_t res);
		while ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			mode    <= 1'($urandom_range(1));
			seq_num <= 16'($urandom);
			payload <= $urandom;
			@(negedge clk);
		end
		start   <= 1'b1;
		mode    <= m;
		seq_num <= s;
		payload <= p;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_release(m, s, p);
		if (typed) begin
			if (has_res)
				release_q = {release_q, res};
		end else begin
			release_q = {release_q, step_q};
		end
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		logic [SEQ_BITS-1:0] ahead;
		logic                m;
		int                  r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30)
				ahead = '0;
			else if (r < 82)
				ahead = 16'($urandom_range(WIN - 1, 1));
			else if (r < 90)
				ahead = 16'(16'hFFFF - $urandom_range(WIN));
			else
				ahead = 16'($urandom_range(16'hFFFF, WIN));
			m = ($urandom_range(99) < 25) ? MODE_ABANDON : MODE_RECORD;
			send_request(m, next_seq + ahead, $urandom, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic report_mismatch(input string fld, input logic [31:0] e, input logic [31:0] a);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, e, a);
		fail_cnt++;
	endtask

	// result checker and run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("tb_in_order_release_buffer NOT OK");
			$finish;
		end else if (arst_n) begin
			if ($isunknown(valid)) begin
				$display("%0t: valid unknown, expected 0 or 1, actual %b", $time, valid);
				fail_cnt++;
			end else if (valid) begin
				got = '{status, out_payload, out_seq, last};
				if (release_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_cnt++;
				end else begin
					want = release_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", want.status, got.status);
					if (got.payload !== want.payload)
						report_mismatch("out_payload", want.payload, got.payload);
					if (got.seq !== want.seq)
						report_mismatch("out_seq", want.seq, got.seq);
					if (got.last !== want.last)
						report_mismatch("last", want.last, got.last);
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		mode      = MODE_RECORD;
		seq_num   = '0;
		payload   = '0;
		fail_cnt  = 0;
		cycle_cnt = 0;
		idle_pct  = 31;
		next_seq  = '0;
		for (int i = 0; i < WIN; i++) begin
			pend_valid[i]   = 1'b0;
			pend_abandon[i] = 1'b0;
			pend_payload[i] = '0;
		end

		// directed table
		add_row(MODE_RECORD,  16'd0,     32'h0000_0000, 1, 1,
			mk_res(STATUS_RELEASE, 32'h0000_0000, 16'd0));
		add_row(MODE_RECORD,  16'd1,     32'hFFFF_FFFF, 1, 1,
			mk_res(STATUS_RELEASE, 32'hFFFF_FFFF, 16'd1));
		add_row(MODE_RECORD,  16'd0,     32'hDEAD_BEEF, 1, 1,
			mk_res(STATUS_REJECT, 32'd0, 16'd0));
		add_row(MODE_ABANDON, 16'd2,     32'hFFFF_FFFF, 1, 0, '0);
		add_row(MODE_RECORD,  16'd19,    32'h0000_0001, 1, 1,
			mk_res(STATUS_REJECT, 32'd0, 16'd19));
		add_row(MODE_RECORD,  16'd18,    32'hA5A5_A5A5, 1, 0, '0);
		add_row(MODE_ABANDON, 16'd4,     32'h5A5A_5A5A, 1, 0, '0);
		add_row(MODE_RECORD,  16'd5,     32'h1234_5678, 1, 0, '0);
		add_row(MODE_RECORD,  16'd5,     32'h8765_4321, 1, 0, '0);
		add_row(MODE_RECORD,  16'd3,     32'h0F0F_0F0F, 0, 0, '0);
		add_row(MODE_RECORD,  16'hFFFF,  32'hFFFF_FFFF, 1, 1,
			mk_res(STATUS_REJECT, 32'd0, 16'hFFFF));
		// fill the whole window ahead of the head, then release it in one drain
		for (int i = 1; i < WIN; i++)
			add_row(MODE_RECORD, 16'(6 + i), ~(32'h1 << i), 0, 0, '0);
		add_row(MODE_RECORD,  16'd6,     32'hC3C3_3C3C, 0, 0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].m, dir_rows[i].s, dir_rows[i].p,
				dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);

		idle_pct = 31;
		send_random(RAND_ITEMS / 3);
		idle_pct = 62;
		send_random(RAND_ITEMS / 3);
		idle_pct = 0;
		send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));

		start <= 1'b0;
		while (release_q.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_cnt == 0)
			$display("tb_in_order_release_buffer OK");
		else
			$display("tb_in_order_release_buffer NOT OK");
		$finish;
	end

endmodule
